>>> rtl/core/mavg_pkg.sv
// Shared widths, types and constants for the moving average filter.
`default_nettype none

package mavg_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam int SAMPLE_W   = 32;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int WIN_W      = ADDR_W + 1;
  localparam int SUM_W      = SAMPLE_W + ADDR_W;
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic        [WIN_W-1:0]    win_t;
  typedef logic        [ADDR_W-1:0]   addr_t;

  // Divider status seen by the top level.
  typedef struct packed {
    logic busy;  // running or holding a quotient
    logic done;  // quotient ready to be taken
  } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/mavg_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module mavg_div
  import mavg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire sum_t      dividend,
  input  wire win_t      divisor,
  input  wire logic      take,
  output div_stat_t      stat,
  output sample_t        quotient
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(SUM_W - 1);

  logic [1:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]     dvd_r, dvd_nxt;    // magnitude, becomes quotient
  logic [WIN_W-1:0]     rem_r, rem_nxt;
  win_t                 dvs_r, dvs_nxt;
  logic                 neg_r, neg_nxt;

  logic [WIN_W:0]       rem_sh;
  logic [WIN_W:0]       rem_sub;
  logic                 fits;
  logic [SUM_W-1:0]     q_signed;

  assign rem_sh  = {rem_r, dvd_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign fits    = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          neg_nxt   = dividend[SUM_W-1];
          dvd_nxt   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
          dvs_nxt   = divisor;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // remainder stays below the divisor, so it fits in WIN_W bits
        rem_nxt = fits ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
        dvd_nxt = {dvd_r[SUM_W-2:0], fits};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign q_signed  = neg_r ? (~dvd_r + 1'b1) : dvd_r;
  assign quotient  = q_signed[SAMPLE_W-1:0];
  assign stat.busy = (state_r != ST_IDLE);
  assign stat.done = (state_r == ST_HOLD);

endmodule

`default_nettype wire

>>> rtl/core/moving_average_filter_core.sv
// Top level of the boxcar moving average filter: delay line memory and sum update.
//
// Usage:
//   in_valid/in_ready/in_sample: signed Q16.16 samples, one item per handshake.
//   out_valid/out_ready/out_average: window mean, truncated toward zero.
//   cfg_valid/cfg_ready/cfg_window_length: window size; any write restarts the
//     filter (sum, fill count and write pointer cleared). Zero acts as 1,
//     values above MAX_WINDOW act as MAX_WINDOW. Write only while idle.
// Timing:
//   A sample that does not complete a window leaves in_ready high; the next item
//   can follow right away.
//   A sample that completes a window starts the divider, which forms the SUM_W
//   (42) quotient bits one at a time. With a free output register the result is
//   on out_average in the same cycle that in_ready rises; until then in_ready
//   stays low and the next item waits. The oldest sample is read in the
//   accept cycle and subtracted from the running sum in the cycle after.
// Reset: window is 1, sum, fill count and pointer are zero. The delay line has
//   no reset; only entries written since the last restart are ever used.
// Stall: a finished result waits in the output register; the divider holds
//   its next quotient until that register frees, and in_ready stays low.
`default_nettype none

module moving_average_filter_core
  import mavg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire sample_t in_sample,
  output logic         out_valid,
  input  wire logic    out_ready,
  output sample_t      out_average,
  input  wire logic    cfg_valid,
  output logic         cfg_ready,
  input  wire win_t    cfg_window_length
);

  localparam win_t WIN_ONE = win_t'(1);
  localparam win_t WIN_MAX = win_t'(MAX_WINDOW);

  // delay line memory
  sample_t mem [MAX_WINDOW];
  sample_t rd_data_r;

  // control and arithmetic state
  win_t    win_r, win_nxt;
  sum_t    sum_r, sum_nxt;
  win_t    fill_r, fill_nxt;
  addr_t   pos_r, pos_nxt;
  logic    sub_pend_r, sub_pend_nxt;
  logic    out_valid_r, out_valid_nxt;
  sample_t out_average_r;

  logic      acc;
  logic      cfg_wr;
  sum_t      s_ext;
  sum_t      sum_add;
  win_t      fill_inc;
  logic      hit;
  addr_t     oldest;
  win_t      win_cfg;
  logic      div_take;
  div_stat_t div_stat;
  sample_t   div_q;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_ready  = ~div_stat.busy;
  assign acc       = in_valid & in_ready;

  assign s_ext    = {{(SUM_W-SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample};
  assign sum_add  = sum_r + s_ext;
  assign fill_inc = fill_r + 1'b1;
  assign hit      = (fill_inc >= win_r);
  // entry that leaves the window: pos - (w - 1), wrapping
  assign oldest   = pos_r - addr_t'(win_r - 1'b1);

  always_comb begin
    priority if (cfg_window_length == '0) begin
      win_cfg = WIN_ONE;
    end else if (cfg_window_length > WIN_MAX) begin
      win_cfg = WIN_MAX;
    end else begin
      win_cfg = cfg_window_length;
    end
  end

  always_comb begin
    win_nxt      = win_r;
    sum_nxt      = sum_r;
    fill_nxt     = fill_r;
    pos_nxt      = pos_r;
    sub_pend_nxt = 1'b0;
    priority if (cfg_wr) begin
      win_nxt  = win_cfg;
      sum_nxt  = '0;
      fill_nxt = '0;
      pos_nxt  = '0;
    end else if (acc) begin
      pos_nxt = pos_r + 1'b1;
      if (hit) begin
        fill_nxt = win_r - 1'b1;
        if (win_r == WIN_ONE) begin
          // oldest is the sample just written: add and remove cancel
          sum_nxt = sum_r;
        end else begin
          sum_nxt      = sum_add;
          sub_pend_nxt = 1'b1;
        end
      end else begin
        fill_nxt = fill_inc;
        sum_nxt  = sum_add;
      end
    end else if (sub_pend_r) begin
      sum_nxt = sum_r - {{(SUM_W-SAMPLE_W){rd_data_r[SAMPLE_W-1]}}, rd_data_r};
    end
  end

  // write new sample, read oldest one; addresses differ whenever the read is used
  always_ff @(posedge clk) begin
    if (acc) begin
      mem[pos_r] <= in_sample;
      rd_data_r  <= mem[oldest];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= WIN_ONE;
      sum_r      <= '0;
      fill_r     <= '0;
      pos_r      <= '0;
      sub_pend_r <= 1'b0;
    end else begin
      win_r      <= win_nxt;
      sum_r      <= sum_nxt;
      fill_r     <= fill_nxt;
      pos_r      <= pos_nxt;
      sub_pend_r <= sub_pend_nxt;
    end
  end

  mavg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (acc & hit),
    .dividend (sum_add),
    .divisor  (win_r),
    .take     (div_take),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // output register, refilled as soon as the current item leaves
  assign div_take = div_stat.done & (~out_valid_r | out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (div_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (div_take) begin
      out_average_r <= div_q;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

endmodule

`default_nettype wire
